[design/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and codes of the viewport frame buffer cursor core
// Request payloads, command codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

	localparam int VIEW_SIZE = 8;
	localparam int VIEW_AW   = 3;
	localparam int ICON_W    = 8;
	localparam int WIN_W     = 4;
	localparam int CUR_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [1:0] CMD_WRITE_PIXEL = 2'd0;
	localparam logic [1:0] CMD_CLEAR       = 2'd1;
	localparam logic [1:0] CMD_LOAD_ICON   = 2'd2;
	localparam logic [1:0] CMD_RENDER      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_Y = 2'd3;

	typedef struct packed {
		logic [1:0]        command;
		logic [3:0]        col;
		logic [3:0]        row;
		logic              pixel_on;
		logic [ICON_W-1:0] icon_bits;
	} in_req_t;

	typedef struct packed {
		logic [VIEW_AW-1:0]   out_row;
		logic [VIEW_SIZE-1:0] row_bits;
		logic                 last_row;
	} out_req_t;

endpackage

`default_nettype wire

[design/viewport_framebuffer_cursor_core.sv]
// ----------------------------------------------------------------------------
// viewport_framebuffer_cursor_core
// One-bit pixel store with pixel, clear and icon-row commands and an 8x8
// rendered window with a cursor overlay.
// ----------------------------------------------------------------------------
// The pixel store is a synchronous memory of STORE_SIZE rows, one row per
// word, with a per-row valid bit that reset and the clear command drop, so
// no clearing pass follows reset and a row that was never written reads as
// zero. One request is worked on at a time; in_stall is high while it is
// busy. Write pixel and load icon row first read the row through the memory
// port, then write the merged row back. Render reads its first row and then
// emits one output request per cycle, eight in all, each row read while the
// previous one is handed out; a stalled output holds the render at its
// current row. The output register lets the next input request be taken
// while the last rendered row still waits. Window offsets are saturated to
// 0..STORE_SIZE-8 when written; a cursor coordinate with its sign bit set
// hides the cursor. Configuration is to be written by the user only while
// the core is idle; the core itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module viewport_framebuffer_cursor_core #(
	parameter int STORE_SIZE = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vfc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire vfc_pkg::in_req_t              in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output vfc_pkg::out_req_t                  out_data
);

	localparam int AW      = $clog2(STORE_SIZE);
	localparam int CW0     = $clog2(STORE_SIZE + 1);
	localparam int CW      = (CW0 > 5) ? CW0 : 5;
	localparam int WIN_MAX = STORE_SIZE - vfc_pkg::VIEW_SIZE;
	localparam int VS      = vfc_pkg::VIEW_SIZE;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WRITE  = 2'd1;
	localparam logic [1:0] ST_RENDER = 2'd2;

	// configuration
	logic [vfc_pkg::WIN_W-1:0]    window_x_q, window_y_q;
	logic signed [vfc_pkg::CUR_W-1:0] cursor_x_q, cursor_y_q;
	logic [CW-1:0]                cfg_ext;
	logic [vfc_pkg::WIN_W-1:0]    cfg_win;

	// control
	logic [1:0]             state_q;
	logic [vfc_pkg::VIEW_AW-1:0] y_q;
	logic [STORE_SIZE-1:0]  row_valid_q;

	// store and its read port
	logic [STORE_SIZE-1:0]  mem [STORE_SIZE];
	logic [STORE_SIZE-1:0]  rdata_q;
	logic                   rvld_q;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   rd_ok;

	// pending write-back
	logic [AW-1:0]          wr_row_q;
	logic [STORE_SIZE-1:0]  wr_mask_q, wr_bits_q;
	logic [STORE_SIZE-1:0]  rd_row, merged;

	// request decode
	logic                   in_acc;
	logic                   acc_pixel, acc_icon, acc_clear, acc_render;
	logic [vfc_pkg::ICON_W-1:0] icon_rev;

	// render path
	logic [vfc_pkg::VIEW_AW-1:0] rd_y;
	logic [CW-1:0]          rd_sr;
	logic                   out_free, out_load;
	logic [STORE_SIZE+VS-1:0] shifted;
	logic [4:0]             sr_out;
	logic [4:0]             cx, cy, wx_lo, wx_hi;
	logic                   cur_hit;
	logic [2:0]             cur_off;
	logic [VS-1:0]          row_bits;
	logic                   out_valid_q;
	vfc_pkg::out_req_t      out_data_q;

	// ---------------- configuration registers ----------------
	assign cfg_ext = CW'(cfg_data[vfc_pkg::WIN_W-1:0]);
	assign cfg_win = (cfg_ext > CW'(WIN_MAX)) ? vfc_pkg::WIN_W'(WIN_MAX)
	                                          : cfg_data[vfc_pkg::WIN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_x_q <= '0;
			window_y_q <= '0;
			cursor_x_q <= '1;
			cursor_y_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				vfc_pkg::REG_WINDOW_X: window_x_q <= cfg_win;
				vfc_pkg::REG_WINDOW_Y: window_y_q <= cfg_win;
				vfc_pkg::REG_CURSOR_X: cursor_x_q <= cfg_data;
				vfc_pkg::REG_CURSOR_Y: cursor_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- request decode ----------------
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// drop pixel writes outside the store and icon rows past the icon
	assign acc_pixel  = in_acc && (in_data.command == vfc_pkg::CMD_WRITE_PIXEL)
	                    && (CW'(in_data.col) < CW'(STORE_SIZE))
	                    && (CW'(in_data.row) < CW'(STORE_SIZE));
	assign acc_icon   = in_acc && (in_data.command == vfc_pkg::CMD_LOAD_ICON)
	                    && (CW'(in_data.row) < CW'(vfc_pkg::ICON_W));
	assign acc_clear  = in_acc && (in_data.command == vfc_pkg::CMD_CLEAR);
	assign acc_render = in_acc && (in_data.command == vfc_pkg::CMD_RENDER);

	// icon MSB lands in column 0
	always_comb begin
		for (int x = 0; x < vfc_pkg::ICON_W; x++) begin
			icon_rev[x] = in_data.icon_bits[vfc_pkg::ICON_W-1-x];
		end
	end

	// ---------------- output handshake ----------------
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_RENDER) && out_free;

	// ---------------- read port ----------------
	// Render reads row window_y + y; the next row is fetched as the current
	// one moves into the output register.
	assign rd_y  = (state_q == ST_IDLE) ? '0 : y_q + 3'd1;
	assign rd_sr = CW'(window_y_q) + CW'(rd_y);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(in_data.row);
		rd_ok   = 1'b1;
		if (acc_pixel || acc_icon) begin
			rd_en = 1'b1;
		end else if (acc_render || (out_load && (y_q != 3'(VS - 1)))) begin
			rd_en   = 1'b1;
			rd_addr = AW'(rd_sr);
			rd_ok   = (rd_sr < CW'(STORE_SIZE));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= 1'b0;
		end else if (rd_en) begin
			rvld_q <= rd_ok && row_valid_q[rd_addr];
		end
	end

	assign rd_row = rvld_q ? rdata_q : '0;

	// ---------------- write-back ----------------
	always_ff @(posedge clk) begin
		if (acc_pixel) begin
			wr_row_q  <= AW'(in_data.row);
			wr_mask_q <= STORE_SIZE'(1'b1) << in_data.col;
			wr_bits_q <= in_data.pixel_on ? (STORE_SIZE'(1'b1) << in_data.col) : '0;
		end else if (acc_icon) begin
			wr_row_q  <= AW'(in_data.row);
			wr_mask_q <= STORE_SIZE'(8'hFF);
			wr_bits_q <= STORE_SIZE'(icon_rev);
		end
	end

	assign merged = (rd_row & ~wr_mask_q) | wr_bits_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			mem[wr_row_q] <= merged;
		end
	end

	// a row reads as zero until written after the last reset or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (acc_clear) begin
			row_valid_q <= '0;
		end else if (state_q == ST_WRITE) begin
			row_valid_q[wr_row_q] <= 1'b1;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			y_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					y_q <= '0;
					if (acc_pixel || acc_icon) begin
						state_q <= ST_WRITE;
					end else if (acc_render) begin
						state_q <= ST_RENDER;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_RENDER: begin
					if (out_load) begin
						y_q <= y_q + 3'd1;
						if (y_q == 3'(VS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------- row formatting ----------------
	assign shifted = {VS'(0), rd_row} >> window_x_q;
	assign sr_out  = 5'(window_y_q) + 5'(y_q);
	assign cx      = {1'b0, cursor_x_q[3:0]};
	assign cy      = {1'b0, cursor_y_q[3:0]};
	assign wx_lo   = 5'(window_x_q);
	assign wx_hi   = 5'(window_x_q) + 5'(VS);
	assign cur_hit = !cursor_x_q[4] && !cursor_y_q[4] && (cy == sr_out)
	                 && (cx >= wx_lo) && (cx < wx_hi);
	assign cur_off = 3'(cx - wx_lo);
	assign row_bits = shifted[VS-1:0] | (cur_hit ? (VS'(1'b1) << cur_off) : '0);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.out_row  <= y_q;
			out_data_q.row_bits <= row_bits;
			out_data_q.last_row <= (y_q == 3'(VS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------- assertions ----------------
	a_rise_in_render: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RENDER)
		else $error("output request appeared outside a render");

	a_render_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc_render |=> (state_q == ST_RENDER) && (y_q == '0))
		else $error("render did not start at row zero");

	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |=> state_q == ST_IDLE)
		else $error("write-back held longer than one cycle");

	a_clear_drops_rows: assert property (@(posedge clk) disable iff (!arst_n)
		acc_clear |=> row_valid_q == '0)
		else $error("clear left a valid row");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.last_row == (out_data_q.out_row == 3'(VS - 1)))
		else $error("last row flag does not match row index");

endmodule

`default_nettype wire
